/* hdl/sdvg_pkg.sv */
// shared constants, types and the helper function of the sphere/dome vertex generator
package sdvg_pkg;

  // size limits and angle format
  localparam int MaxSlices = 256;
  localparam int MaxStacks = 256;
  localparam int AngleBits = 16;

  // fixed field widths
  localparam int StackW  = 9;
  localparam int SliceW  = 8;
  localparam int RadiusW = 16;
  localparam int CountW  = 9;
  localparam int CfgW    = 16;
  localparam int PosW    = 17;
  localparam int NormW   = 16;

  // divider: quotient bits and remainder width
  localparam int QuotW = AngleBits + 1;
  localparam int NumW  = StackW + AngleBits + 1;
  localparam int DenW  = CountW + 2;
  localparam int DivA  = (QuotW + 2) / 3;
  localparam int DivC  = QuotW - 2 * DivA;

  // sine datapath widths (q30 magnitudes)
  localparam int XW   = 31;
  localparam int MagW = 32;
  localparam int RPosW = 18;
  localparam int NMagW = 15;

  // pipeline depth from input register to output register
  localparam int NumStages = 11;

  localparam logic [MagW-1:0] PolyA = 32'd1686629713;
  localparam logic [MagW-1:0] PolyB = 32'd688904866;
  localparam logic [MagW-1:0] PolyC = 32'd76016977;
  localparam logic [XW-1:0]   OneQ30 = 31'h4000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_SLICE_COUNT = 3'd1,
    REG_STACK_COUNT = 3'd2,
    REG_INVERT      = 3'd3,
    REG_DOME_MODE   = 3'd4
  } cfg_reg_e;

  // running state of one restoring divider
  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QuotW-1:0] lo;
  } div_t;

  // n restoring division steps; lo shifts dividend bits out and quotient bits in
  function automatic div_t div_run(input div_t d, input logic [DenW-1:0] den,
                                   input int n);
    div_t        r;
    logic [DenW:0] rs;
    r = d;
    for (int i = 0; i < QuotW; i++) begin
      if (i < n) begin
        rs = {r.rem, r.lo[QuotW-1]};
        if (rs >= {1'b0, den}) begin
          rs = rs - {1'b0, den};
          r.lo = {r.lo[QuotW-2:0], 1'b1};
        end else begin
          r.lo = {r.lo[QuotW-2:0], 1'b0};
        end
        r.rem = rs[DenW-1:0];
      end
    end
    return r;
  endfunction

endpackage

/* hdl/sphere_dome_vertex_generator.sv */
// sphere/dome vertex generator: pipelined divider, sine polynomial and scaling
//
// Usage: each input transaction carries a stack index and a slice index and
// produces exactly one output transaction with the vertex position (Q8.8),
// the unit normal (Q1.15) and an in_range flag. Out-of-range indices or a bad
// slice/stack count give in_range 0 and all other fields 0.
// Channels use valid/stall: a transaction moves on an edge with valid high and
// stall low. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_data_i); the user must write it only while the block holds no
// transaction; the block itself does not enforce this. One transaction is
// accepted every cycle unless the output stalls. The pipeline is an 11-stage
// register chain: an input stage holding the divider set-up, three divider
// stages of 6/6/5 quotient bits, four sine polynomial stages (one multiply
// each), a product stage, a scaling stage and the output register.
// When the receiver stalls with a valid output, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads radius 1.0, 16 slices, 16 stacks,
// invert 0 and sphere mode.
module sphere_dome_vertex_generator
  import sdvg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [StackW-1:0]       stack_index_i,
  input  logic [SliceW-1:0]       slice_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PosW-1:0]  pos_x_o,
  output logic signed [PosW-1:0]  pos_y_o,
  output logic signed [PosW-1:0]  pos_z_o,
  output logic signed [NormW-1:0] norm_x_o,
  output logic signed [NormW-1:0] norm_y_o,
  output logic signed [NormW-1:0] norm_z_o,
  output logic                    in_range_o
);

  // configuration registers
  logic [RadiusW-1:0] radius_q;
  logic [CountW-1:0]  slice_count_q;
  logic [CountW-1:0]  stack_count_q;
  logic               invert_q;
  logic               dome_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= 16'd256;
      slice_count_q <= 9'd16;
      stack_count_q <= 9'd16;
      invert_q      <= 1'b0;
      dome_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RADIUS:      radius_q      <= cfg_data_i[RadiusW-1:0];
        REG_SLICE_COUNT: slice_count_q <= cfg_data_i[CountW-1:0];
        REG_STACK_COUNT: stack_count_q <= cfg_data_i[CountW-1:0];
        REG_INVERT:      invert_q      <= cfg_data_i[0];
        REG_DOME_MODE:   dome_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] ok_q;
  logic                 en;

  assign en          = !v_q[NumStages-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // range check and divider set-up
  logic              ok_c;
  logic [DenW-1:0]   den_c [2];
  logic [NumW-1:0]   num_c [2];
  div_t              div0_c [2];

  always_comb begin
    ok_c = (slice_count_q >= 9'd1) && (int'(slice_count_q) <= MaxSlices) &&
           (stack_count_q >= 9'd2) && (int'(stack_count_q) <= MaxStacks) &&
           ({1'b0, slice_index_i} < slice_count_q) &&
           (dome_mode_q ? (stack_index_i < stack_count_q)
                        : (stack_index_i <= stack_count_q));
    den_c[0] = DenW'(slice_count_q);
    den_c[1] = dome_mode_q ? ({stack_count_q, 2'b00} - DenW'(4))
                           : {1'b0, stack_count_q, 1'b0};
    num_c[0] = (NumW'(slice_index_i) << AngleBits) + NumW'(den_c[0] >> 1);
    num_c[1] = (NumW'(stack_index_i) << AngleBits) + NumW'(den_c[1] >> 1);
    for (int l = 0; l < 2; l++) begin
      div0_c[l].rem = DenW'(num_c[l] >> QuotW);
      div0_c[l].lo  = num_c[l][QuotW-1:0];
    end
  end

  // divider stages: stage 0 holds the set-up, stages 1..3 run the steps
  div_t            dv_q  [4][2];
  logic [DenW-1:0] den_q [4][2];
  div_t            dv_d  [4][2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dv_d[0][l] = div0_c[l];
      dv_d[1][l] = div_run(dv_q[0][l], den_q[0][l], DivA);
      dv_d[2][l] = div_run(dv_q[1][l], den_q[1][l], DivA);
      dv_d[3][l] = div_run(dv_q[2][l], den_q[2][l], DivC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dv_q[0][l]  <= dv_d[0][l];
        den_q[0][l] <= den_c[l];
        for (int k = 1; k < 4; k++) begin
          dv_q[k][l]  <= dv_d[k][l];
          den_q[k][l] <= den_q[k-1][l];
        end
      end
    end
  end

  // range flag travels alongside the data
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= {ok_q[NumStages-2:0], ok_c};
    end
  end

  // sine lanes: 0 sin az, 1 cos az, 2 sin polar, 3 cos polar
  logic [AngleBits-1:0] ang_c [4];
  logic [XW-1:0]        x_c   [4];
  logic [2*XW-1:0]      xx_c  [4];

  always_comb begin
    ang_c[0] = dv_q[3][0].lo[AngleBits-1:0];
    ang_c[1] = ang_c[0] + AngleBits'(1 << (AngleBits - 2));
    ang_c[2] = dv_q[3][1].lo[AngleBits-1:0];
    ang_c[3] = ang_c[2] + AngleBits'(1 << (AngleBits - 2));
    for (int l = 0; l < 4; l++) begin
      x_c[l] = XW'(ang_c[l][AngleBits-3:0]) << (32 - AngleBits);
      if (ang_c[l][AngleBits-2]) begin
        x_c[l] = OneQ30 - x_c[l];
      end
      xx_c[l] = (2*XW)'(x_c[l]) * (2*XW)'(x_c[l]);
    end
  end

  // stage 4: folded x and x squared
  logic [XW-1:0]   x4_q  [4];
  logic [MagW-1:0] x24_q [4];
  logic            sg4_q [4];
  // stage 5: b - c*x2
  logic [XW-1:0]   x5_q  [4];
  logic [MagW-1:0] x25_q [4];
  logic [MagW-1:0] t5_q  [4];
  logic            sg5_q [4];
  // stage 6: a - t*x2
  logic [XW-1:0]   x6_q  [4];
  logic [MagW-1:0] t6_q  [4];
  logic            sg6_q [4];
  // stage 7: t*x, the sine magnitude
  logic [MagW-1:0] m7_q  [4];
  logic            sg7_q [4];

  logic [2*MagW-1:0] p5_c [4];
  logic [2*MagW-1:0] p6_c [4];
  logic [2*MagW-1:0] p7_c [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p5_c[l] = (2*MagW)'(PolyC) * (2*MagW)'(x24_q[l]);
      p6_c[l] = (2*MagW)'(t5_q[l]) * (2*MagW)'(x25_q[l]);
      p7_c[l] = (2*MagW)'(t6_q[l]) * (2*MagW)'(x6_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        x4_q[l]  <= x_c[l];
        x24_q[l] <= MagW'(xx_c[l] >> 30);
        sg4_q[l] <= ang_c[l][AngleBits-1];
        x5_q[l]  <= x4_q[l];
        x25_q[l] <= x24_q[l];
        t5_q[l]  <= PolyB - MagW'(p5_c[l] >> 30);
        sg5_q[l] <= sg4_q[l];
        x6_q[l]  <= x5_q[l];
        t6_q[l]  <= PolyA - MagW'(p6_c[l] >> 30);
        sg6_q[l] <= sg5_q[l];
        m7_q[l]  <= MagW'(p7_c[l] >> 30);
        sg7_q[l] <= sg6_q[l];
      end
    end
  end

  // stage 8: normal components in sign/magnitude q30
  logic [MagW-1:0]   qm8_q [3];
  logic              qs8_q [3];
  logic [2*MagW-1:0] px_c, pz_c;

  assign px_c = (2*MagW)'(m7_q[1]) * (2*MagW)'(m7_q[2]);
  assign pz_c = (2*MagW)'(m7_q[0]) * (2*MagW)'(m7_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      qm8_q[0] <= MagW'(px_c >> 30);
      qs8_q[0] <= sg7_q[1] ^ sg7_q[2];
      qm8_q[1] <= m7_q[3];
      qs8_q[1] <= sg7_q[3];
      qm8_q[2] <= MagW'(pz_c >> 30);
      qs8_q[2] <= sg7_q[0] ^ sg7_q[2];
    end
  end

  // stage 9: radius scaling and q1.15 rounding with saturation
  logic [RPosW-1:0] pm9_q [3];
  logic [NMagW-1:0] nm9_q [3];
  logic             qs9_q [3];
  logic [RadiusW+MagW-1:0] pr_c [3];
  logic [MagW-1:0]         nr_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_c[i] = (RadiusW+MagW)'(radius_q) * (RadiusW+MagW)'(qm8_q[i]) +
                (RadiusW+MagW)'(1 << 29);
      nr_c[i] = (qm8_q[i] + MagW'(1 << 14)) >> 15;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pm9_q[i] <= RPosW'(pr_c[i] >> 30);
        nm9_q[i] <= (nr_c[i] > MagW'(32767)) ? NMagW'(32767) : nr_c[i][NMagW-1:0];
        qs9_q[i] <= qs8_q[i];
      end
    end
  end

  // stage 10: signs, invert and range masking into the output register
  logic [PosW-1:0]  pos_d  [3];
  logic [NormW-1:0] norm_d [3];
  logic [PosW-1:0]  pos_q  [3];
  logic [NormW-1:0] norm_q [3];
  logic             ps_c, ns_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps_c = qs9_q[i] ^ (invert_q && !dome_mode_q);
      ns_c = qs9_q[i] ^ (invert_q && dome_mode_q);
      pos_d[i]  = ps_c ? -PosW'(pm9_q[i]) : PosW'(pm9_q[i]);
      norm_d[i] = ns_c ? -{1'b0, nm9_q[i]} : {1'b0, nm9_q[i]};
      if (!ok_q[NumStages-2]) begin
        pos_d[i]  = '0;
        norm_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= pos_d[i];
        norm_q[i] <= norm_d[i];
      end
    end
  end

  assign pos_x_o    = pos_q[0];
  assign pos_y_o    = pos_q[1];
  assign pos_z_o    = pos_q[2];
  assign norm_x_o   = norm_q[0];
  assign norm_y_o   = norm_q[1];
  assign norm_z_o   = norm_q[2];
  assign in_range_o = ok_q[NumStages-1];

endmodule

/* hdl/sdvg_checker.sv */
// port-level checks of the vertex generator, bound to the top level
module sdvg_props
  import sdvg_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [PosW-1:0]  pos_x_o,
  input logic signed [PosW-1:0]  pos_y_o,
  input logic signed [PosW-1:0]  pos_z_o,
  input logic signed [NormW-1:0] norm_x_o,
  input logic signed [NormW-1:0] norm_y_o,
  input logic signed [NormW-1:0] norm_z_o,
  input logic                    in_range_o
);

  // a stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped under stall");

  // input only stalls when a finished result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // out-of-range results carry all-zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |->
      pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0 &&
      norm_x_o == 0 && norm_y_o == 0 && norm_z_o == 0)
    else $error("nonzero fields on out-of-range result");

  // normals are saturated symmetrically
  a_norm_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> norm_x_o != -16'sd32768 && norm_y_o != -16'sd32768 &&
                    norm_z_o != -16'sd32768)
    else $error("normal outside symmetric range");

endmodule

bind sphere_dome_vertex_generator sdvg_props u_sdvg_props (.*);

/* dv/sdvg_checker.sv */
// vertex predictor and output checker for the sphere/dome vertex generator
`timescale 1ns / 1ps

module sdvg_checker
  import sdvg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [StackW-1:0]       stack_index_i,
  input  logic [SliceW-1:0]       slice_index_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic signed [PosW-1:0]  pos_z_i,
  input  logic signed [NormW-1:0] norm_x_i,
  input  logic signed [NormW-1:0] norm_y_i,
  input  logic signed [NormW-1:0] norm_z_i,
  input  logic                    in_range_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [PosW-1:0]  px;
    logic signed [PosW-1:0]  py;
    logic signed [PosW-1:0]  pz;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
    logic                    ok;
  } vertex_t;

  localparam logic [63:0] CoefA = 64'd1686629713;
  localparam logic [63:0] CoefB = 64'd688904866;
  localparam logic [63:0] CoefC = 64'd76016977;

  // mirror of the configuration registers
  logic [RadiusW-1:0] radius_q;
  logic [CountW-1:0]  slices_q;
  logic [CountW-1:0]  stacks_q;
  logic               invert_q;
  logic               dome_q;

  vertex_t vertex_q[$];

  // sine of a turn fraction, q30, odd polynomial over the folded quadrant
  function automatic longint sine_q30(logic [63:0] ang);
    logic [63:0] quad, x, x2, t;
    ang  = ang & ((64'd1 << AngleBits) - 1);
    quad = ang >> (AngleBits - 2);
    x    = (ang & ((64'd1 << (AngleBits - 2)) - 1)) << (32 - AngleBits);
    if (quad[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    t  = (CoefC * x2) >> 30;
    t  = CoefB - t;
    t  = (t * x2) >> 30;
    t  = CoefA - t;
    t  = (t * x) >> 30;
    return quad[1] ? -longint'(t) : longint'(t);
  endfunction

  // q30 product truncated on the magnitude
  function automatic longint mul_mag_q30(longint a, longint b);
    logic [63:0] m;
    m = (64'((a < 0) ? -a : a) * 64'((b < 0) ? -b : b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // shift with rounding half away from zero
  function automatic longint shift_round(longint v, int sh);
    logic [63:0] m;
    m = (64'((v < 0) ? -v : v) + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] turn_of(logic [63:0] idx, logic [63:0] den);
    return (((idx << AngleBits) + den / 2) / den) & ((64'd1 << AngleBits) - 1);
  endfunction

  function automatic vertex_t predict_vertex(logic [StackW-1:0] stk,
                                             logic [SliceW-1:0] slc);
    vertex_t     v;
    logic [63:0] az, pol;
    longint      sa, ca, sp, cp, pv, nv;
    longint      q[3];
    v = '0;
    v.ok = slices_q >= 1 && slices_q <= MaxSlices && stacks_q >= 2 &&
           stacks_q <= MaxStacks && slc < slices_q &&
           (dome_q ? (stk < stacks_q) : (stk <= stacks_q));
    if (v.ok) begin
      az  = turn_of(slc, slices_q);
      pol = dome_q ? turn_of(stk, 4 * (stacks_q - 1)) : turn_of(stk, 2 * stacks_q);
      sa = sine_q30(az);
      ca = sine_q30(az + (64'd1 << (AngleBits - 2)));
      sp = sine_q30(pol);
      cp = sine_q30(pol + (64'd1 << (AngleBits - 2)));
      q[0] = mul_mag_q30(ca, sp);
      q[1] = cp;
      q[2] = mul_mag_q30(sa, sp);
      for (int i = 0; i < 3; i++) begin
        pv = shift_round(longint'(radius_q) * q[i], 30);
        nv = shift_round(q[i], 15);
        if (nv > 32767) nv = 32767;
        if (nv < -32767) nv = -32767;
        if (invert_q) begin
          if (dome_q) nv = -nv;
          else pv = -pv;
        end
        case (i)
          0: begin v.px = pv[PosW-1:0]; v.nx = nv[NormW-1:0]; end
          1: begin v.py = pv[PosW-1:0]; v.ny = nv[NormW-1:0]; end
          default: begin v.pz = pv[PosW-1:0]; v.nz = nv[NormW-1:0]; end
        endcase
      end
    end
    return v;
  endfunction

  assign pending_o = vertex_q.size();

  // register mirror
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      slices_q <= 9'd16;
      stacks_q <= 9'd16;
      invert_q <= 1'b0;
      dome_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RADIUS:      radius_q <= cfg_data_i[RadiusW-1:0];
        REG_SLICE_COUNT: slices_q <= cfg_data_i[CountW-1:0];
        REG_STACK_COUNT: stacks_q <= cfg_data_i[CountW-1:0];
        REG_INVERT:      invert_q <= cfg_data_i[0];
        REG_DOME_MODE:   dome_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin
    vertex_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        vertex_q.push_back(predict_vertex(stack_index_i, slice_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("output transaction with no expected vertex");
          fail_count_o++;
        end else begin
          e = vertex_q.pop_front();
          if (pos_x_i !== e.px) begin
            $error("pos_x expected %0d got %0d", e.px, pos_x_i); fail_count_o++;
          end
          if (pos_y_i !== e.py) begin
            $error("pos_y expected %0d got %0d", e.py, pos_y_i); fail_count_o++;
          end
          if (pos_z_i !== e.pz) begin
            $error("pos_z expected %0d got %0d", e.pz, pos_z_i); fail_count_o++;
          end
          if (norm_x_i !== e.nx) begin
            $error("norm_x expected %0d got %0d", e.nx, norm_x_i); fail_count_o++;
          end
          if (norm_y_i !== e.ny) begin
            $error("norm_y expected %0d got %0d", e.ny, norm_y_i); fail_count_o++;
          end
          if (norm_z_i !== e.nz) begin
            $error("norm_z expected %0d got %0d", e.nz, norm_z_i); fail_count_o++;
          end
          if (in_range_i !== e.ok) begin
            $error("in_range expected %0d got %0d", e.ok, in_range_i); fail_count_o++;
          end
        end
      end
    end
  end

endmodule

/* dv/tb_sphere_dome_vertex_generator.sv */
// testbench top of the sphere/dome vertex generator: stimulus and verdict
`timescale 1ns / 1ps

module tb_sphere_dome_vertex_generator;
  import sdvg_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int NumCfg = 12;
  localparam int ItemsPerPhase = 140;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [2:0]              cfg_index;
  logic [CfgW-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [StackW-1:0]       stack_index;
  logic [SliceW-1:0]       slice_index;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [PosW-1:0]  pos_x, pos_y, pos_z;
  logic signed [NormW-1:0] norm_x, norm_y, norm_z;
  logic                    in_range;
  int                      fail_count;
  int                      pending;

  // idle percentages of sender and receiver
  int send_idle_pct;
  int recv_stall_pct;

  // configuration settings per phase
  int cfg_radius[NumCfg] = '{256, 65535, 0, 65535, 12345, 40000, 256, 256, 256, 256, 777,
                             65535};
  int cfg_slices[NumCfg] = '{16, 256, 1, 256, 7, 3, 0, 300, 16, 16, 100, 255};
  int cfg_stacks[NumCfg] = '{16, 256, 2, 256, 9, 5, 16, 16, 1, 257, 200, 2};
  int cfg_invert[NumCfg] = '{0, 1, 0, 1, 0, 1, 0, 0, 0, 1, 1, 0};
  int cfg_dome[NumCfg]   = '{0, 0, 1, 1, 1, 0, 0, 0, 1, 0, 1, 0};

  sphere_dome_vertex_generator uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .stack_index_i(stack_index), .slice_index_i(slice_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z),
    .norm_x_o(norm_x), .norm_y_o(norm_y), .norm_z_o(norm_z),
    .in_range_o(in_range)
  );

  sdvg_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .stack_index_i(stack_index), .slice_index_i(slice_index),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .in_range_i(in_range),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_vertex(int stk, int slc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    stack_index <= stk[StackW-1:0];
    slice_index <= slc[SliceW-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // drain the pipeline so registers may be written
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CfgW-1:0];
    @(posedge clk_i);
  endtask

  // random vertex, mostly inside the configured grid
  task automatic random_vertex(int p);
    int stk_max, slc_max;
    slc_max = (cfg_slices[p] >= 1 && cfg_slices[p] <= MaxSlices) ? cfg_slices[p] - 1 : 255;
    stk_max = (cfg_stacks[p] >= 2 && cfg_stacks[p] <= MaxStacks) ?
              cfg_stacks[p] - cfg_dome[p] : 511;
    if ($urandom_range(99) < 80)
      send_vertex($urandom_range(stk_max), $urandom_range(slc_max));
    else
      send_vertex($urandom_range(511), $urandom_range(255));
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_RADIUS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    stack_index = '0;
    slice_index = '0;
    out_stall   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed vertices under the reset settings: poles, equator, grid edges
    send_vertex(0, 0);
    send_vertex(16, 0);
    send_vertex(8, 0);
    send_vertex(8, 4);
    send_vertex(8, 8);
    send_vertex(8, 12);
    send_vertex(3, 15);
    send_vertex(16, 15);
    send_vertex(17, 0);
    send_vertex(0, 16);
    send_vertex(511, 255);
    send_vertex(256, 128);
    send_vertex(255, 127);
    wait_idle();

    for (int p = 0; p < NumCfg; p++) begin
      write_reg(REG_RADIUS, cfg_radius[p]);
      write_reg(REG_SLICE_COUNT, cfg_slices[p]);
      write_reg(REG_STACK_COUNT, cfg_stacks[p]);
      write_reg(REG_INVERT, cfg_invert[p]);
      write_reg(REG_DOME_MODE, cfg_dome[p]);
      // unknown register index, must be ignored
      write_reg(RegUnused, $urandom_range(65535));
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // grid corners of this setting
      send_vertex(0, 0);
      send_vertex(cfg_stacks[p], cfg_slices[p] - 1);
      send_vertex(cfg_stacks[p] - 1, cfg_slices[p]);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        random_vertex(p);
        // sender holds off until the pipeline has emptied
        if (i == ItemsPerPhase / 2 && p == 3)
          wait_idle();
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sphere_dome_vertex_generator.f */
hdl/sdvg_pkg.sv
hdl/sphere_dome_vertex_generator.sv
hdl/sdvg_checker.sv
dv/sdvg_checker.sv
dv/tb_sphere_dome_vertex_generator.sv
